>>> src/cbfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfs_pkg
// Types and constants shared by the cyclic best-first node selector.
// ----------------------------------------------------------------------------
package cbfs_pkg;

	localparam int LEVELS_DEF      = 16;
	localparam int ENTRIES_DEF     = 256;
	localparam int HANDLE_BITS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_SAVE = 2'd0,
		CMD_NEXT = 2'd1,
		CMD_MARK = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        node_handle;
		logic [3:0]         node_depth;
		logic signed [31:0] node_priority;
		logic               node_dominated;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_handle;
		logic [3:0]  out_depth;
		logic        out_dominated;
		logic [8:0]  pending_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SAVE_DEC,
		S_WRITE,
		S_NEXT_LVL,
		S_POP_RD,
		S_POP_WAIT,
		S_POP_CHK,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> src/cbfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> src/cyclic_best_first_node_selector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_best_first_node_selector_unit
// Bounded node store grouped by level with one held best child.
// ----------------------------------------------------------------------------
// channel | dir | handshake       | payload
// in      | in  | in_valid/stall  | cbfs_pkg::in_item_t
// out     | out | out_valid/stall | cbfs_pkg::out_item_t
//
// A save or mark sweeps the store once through one RAM port and one shared
// compare unit; a mark holds the sweep while it rewrites a matching entry.
// A next sweeps once per level visited and again after each dominated pop;
// a held child, an empty store or the unused command answer without a
// sweep.
// Reset clears valid bits and control registers; in_stall is high from
// acceptance until the result item is taken.
// ----------------------------------------------------------------------------
module cyclic_best_first_node_selector_unit #(
	parameter int LEVELS      = cbfs_pkg::LEVELS_DEF,
	parameter int ENTRIES     = cbfs_pkg::ENTRIES_DEF,
	parameter int HANDLE_BITS = cbfs_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire cbfs_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output cbfs_pkg::out_item_t      out_item
);
	localparam int AW = $clog2(ENTRIES);
	localparam int LW = $clog2(LEVELS);
	localparam int CW = $clog2(ENTRIES + 2);
	localparam int RW = HANDLE_BITS + LW + 32 + 1;

	cbfs_pkg::state_t state_q, state_d;

	logic [ENTRIES-1:0] valid_q;
	logic [1:0]              cmd_q;
	logic [HANDLE_BITS-1:0]  h_q;
	logic [LW-1:0]           lvl_q;
	logic signed [31:0]      pri_q;
	logic                    dom_q;

	logic                    hv_q;
	logic [HANDLE_BITS-1:0]  hh_q;
	logic [LW-1:0]           hl_q;
	logic signed [31:0]      hp_q;
	logic                    hd_q;

	logic [LW:0] liu_q;
	logic        dive_none_q, expl_none_q;
	logic [LW-1:0] dive_q, expl_q;
	logic [8:0]  pend_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] addr_s1;
	logic          rd_s1;
	logic          free_f_q, best_f_q, found_q;
	logic [AW-1:0] free_q, best_q;
	logic signed [31:0] bestp_q;
	logic [LW-1:0] cur_q;
	logic [LW:0]   lvlcnt_q;

	logic [1:0]    st_q;
	logic [HANDLE_BITS-1:0] oh_q;
	logic [LW-1:0] ol_q;
	logic          od_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [RW-1:0] wdata, rdata;
	logic [HANDLE_BITS-1:0] r_h;
	logic [LW-1:0] r_l;
	logic signed [31:0] r_p;
	logic          r_d;

	assign {r_h, r_l, r_p, r_d} = rdata;

	cbfs_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic sweep_end;
	assign sweep_end = (cnt_q == CW'(ENTRIES + 1));

	// mark rewrite takes the port for a cycle; the sweep holds meanwhile
	logic mark_wr;
	assign mark_wr = (state_q == cbfs_pkg::S_SCAN) && rd_s1 &&
		(cmd_q == cbfs_pkg::CMD_MARK) && valid_q[addr_s1] && (r_h == h_q);

	logic [LW-1:0] lvl_sat;
	assign lvl_sat = (in_item.node_depth >= 4'(LEVELS - 1 > 15 ? 15 : LEVELS - 1)) &&
		(32'(in_item.node_depth) >= 32'(LEVELS - 1)) ? LW'(LEVELS - 1) :
		LW'(in_item.node_depth);

	logic to_store, swap;
	assign to_store = (!expl_none_q && lvl_q == expl_q) || (hv_q && !(hp_q < pri_q));
	assign swap     = !to_store && hv_q;

	logic [LW-1:0] start_lvl;
	always_comb begin
		if (dive_none_q || (LW+1)'(dive_q) + 1'b1 >= liu_q) begin
			start_lvl = '0;
		end else begin
			start_lvl = dive_q + 1'b1;
		end
	end

	logic [LW-1:0] cur_inc;
	assign cur_inc = ((LW+1)'(cur_q) + 1'b1 >= liu_q) ? '0 : cur_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbfs_pkg::S_IDLE:
				if (in_valid) begin
					state_d = cbfs_pkg::S_SCAN;
					if (in_item.cmd == cbfs_pkg::CMD_NEXT) begin
						if (hv_q || pend_q == '0 || liu_q == '0) begin
							state_d = cbfs_pkg::S_DONE;
						end
					end else if (in_item.cmd == cbfs_pkg::CMD_NOP) begin
						state_d = cbfs_pkg::S_DONE;
					end
				end
			cbfs_pkg::S_SCAN:
				if (sweep_end) begin
					unique case (cmd_q)
						cbfs_pkg::CMD_SAVE: state_d = cbfs_pkg::S_SAVE_DEC;
						cbfs_pkg::CMD_NEXT: state_d = cbfs_pkg::S_NEXT_LVL;
						default:            state_d = cbfs_pkg::S_DONE;
					endcase
				end
			cbfs_pkg::S_SAVE_DEC:
				state_d = ((to_store || swap) && free_f_q) ? cbfs_pkg::S_WRITE :
					cbfs_pkg::S_DONE;
			cbfs_pkg::S_WRITE:  state_d = cbfs_pkg::S_DONE;
			cbfs_pkg::S_NEXT_LVL:
				if (found_q) begin
					state_d = best_f_q ? cbfs_pkg::S_POP_RD : cbfs_pkg::S_DONE;
				end else if (best_f_q) begin
					state_d = cbfs_pkg::S_POP_RD;
				end else if (lvlcnt_q + 1'b1 >= liu_q) begin
					state_d = cbfs_pkg::S_DONE;
				end else begin
					state_d = cbfs_pkg::S_SCAN;
				end
			cbfs_pkg::S_POP_RD:   state_d = cbfs_pkg::S_POP_WAIT;
			cbfs_pkg::S_POP_WAIT: state_d = cbfs_pkg::S_POP_CHK;
			cbfs_pkg::S_POP_CHK:
				state_d = r_d ? cbfs_pkg::S_SCAN : cbfs_pkg::S_DONE;
			cbfs_pkg::S_DONE:
				if (!out_stall) state_d = cbfs_pkg::S_IDLE;
			default: state_d = cbfs_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != cbfs_pkg::S_IDLE);
		out_valid = (state_q == cbfs_pkg::S_DONE);
		out_item.status        = st_q;
		out_item.out_handle    = 16'(oh_q);
		out_item.out_depth     = 4'(ol_q);
		out_item.out_dominated = od_q;
		out_item.pending_count = pend_q;
		we    = 1'b0;
		addr  = cnt_q[AW-1:0];
		wdata = {r_h, r_l, r_p, 1'b1};
		if (mark_wr) begin
			we = 1'b1;
			addr = addr_s1;
		end
		if (state_q == cbfs_pkg::S_WRITE) begin
			we = 1'b1;
			addr = free_q;
			wdata = swap ? {hh_q, hl_q, hp_q, hd_q} : {h_q, lvl_q, pri_q, dom_q};
		end
		if (state_q == cbfs_pkg::S_POP_RD || state_q == cbfs_pkg::S_POP_WAIT) begin
			addr = best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbfs_pkg::S_IDLE;
			valid_q     <= '0;
			hv_q        <= 1'b0;
			liu_q       <= '0;
			dive_none_q <= 1'b1;
			expl_none_q <= 1'b1;
			pend_q      <= '0;
			rd_s1       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == cbfs_pkg::S_SCAN) && (cnt_q < CW'(ENTRIES)) && !mark_wr;
			unique case (state_q)
				cbfs_pkg::S_IDLE:
					if (in_valid) begin
						cmd_q    <= in_item.cmd;
						h_q      <= HANDLE_BITS'(in_item.node_handle);
						lvl_q    <= lvl_sat;
						pri_q    <= in_item.node_priority;
						dom_q    <= in_item.node_dominated;
						cnt_q    <= '0;
						free_f_q <= 1'b0;
						best_f_q <= 1'b0;
						lvlcnt_q <= '0;
						cur_q    <= start_lvl;
						if (in_item.cmd == cbfs_pkg::CMD_NEXT && hv_q) begin
							st_q        <= cbfs_pkg::ST_OK;
							found_q     <= 1'b0;
							hv_q        <= 1'b0;
							expl_none_q <= 1'b0;
							expl_q      <= hl_q;
							pend_q      <= pend_q - 1'b1;
							oh_q        <= hh_q;
							ol_q        <= hl_q;
							od_q        <= hd_q;
						end else begin
							oh_q <= '0;
							ol_q <= '0;
							od_q <= 1'b0;
							if (in_item.cmd == cbfs_pkg::CMD_NEXT &&
								(pend_q == '0 || liu_q == '0)) begin
								st_q <= cbfs_pkg::ST_EMPTY;
							end else begin
								st_q <= cbfs_pkg::ST_OK;
							end
							if (in_item.cmd == cbfs_pkg::CMD_MARK && hv_q &&
								hh_q == HANDLE_BITS'(in_item.node_handle)) begin
								hd_q    <= 1'b1;
								found_q <= 1'b1;
							end else begin
								found_q <= 1'b0;
							end
						end
					end
				cbfs_pkg::S_SCAN: begin
					if (!sweep_end && !mark_wr) cnt_q <= cnt_q + 1'b1;
					if (cnt_q < CW'(ENTRIES) && !mark_wr) addr_s1 <= cnt_q[AW-1:0];
					if (!free_f_q && cnt_q < CW'(ENTRIES) && !valid_q[cnt_q[AW-1:0]]) begin
						free_f_q <= 1'b1;
						free_q   <= cnt_q[AW-1:0];
					end
					if (rd_s1 && valid_q[addr_s1]) begin
						if (cmd_q == cbfs_pkg::CMD_MARK && r_h == h_q) found_q <= 1'b1;
						if (cmd_q == cbfs_pkg::CMD_NEXT && r_l == cur_q &&
							(!best_f_q || r_p > bestp_q)) begin
							best_f_q <= 1'b1;
							best_q   <= addr_s1;
							bestp_q  <= r_p;
						end
					end
					if (sweep_end && cmd_q == cbfs_pkg::CMD_MARK && !found_q) begin
						st_q <= cbfs_pkg::ST_NOTFOUND;
					end
				end
				cbfs_pkg::S_SAVE_DEC:
					if ((to_store || swap) && !free_f_q) begin
						st_q <= cbfs_pkg::ST_FULL;
					end else begin
						if (!to_store && !swap) begin
							hv_q <= 1'b1;
							hh_q <= h_q; hl_q <= lvl_q; hp_q <= pri_q; hd_q <= dom_q;
						end
						if ((LW+1)'(lvl_q) + 1'b1 > liu_q) liu_q <= (LW+1)'(lvl_q) + 1'b1;
						pend_q <= pend_q + 1'b1;
					end
				cbfs_pkg::S_WRITE: begin
					valid_q[free_q] <= 1'b1;
					if (swap) begin
						hh_q <= h_q; hl_q <= lvl_q; hp_q <= pri_q; hd_q <= dom_q;
					end
				end
				cbfs_pkg::S_NEXT_LVL: begin
					cnt_q    <= '0;
					free_f_q <= 1'b1;
					if (best_f_q) begin
						found_q     <= 1'b1;
						valid_q[best_q] <= 1'b0;
						pend_q      <= pend_q - 1'b1;
						dive_none_q <= 1'b0;
						dive_q      <= cur_q;
						expl_none_q <= 1'b0;
						expl_q      <= cur_q;
					end else if (!found_q) begin
						if (lvlcnt_q + 1'b1 >= liu_q) st_q <= cbfs_pkg::ST_EMPTY;
						lvlcnt_q <= lvlcnt_q + 1'b1;
						cur_q    <= cur_inc;
					end
					best_f_q <= 1'b0;
				end
				cbfs_pkg::S_POP_CHK: begin
					oh_q <= r_h;
					ol_q <= r_l;
					od_q <= r_d;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/cbfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfs_checker
// Port-level checks for the node selector, bound to the top level.
// ----------------------------------------------------------------------------
module cbfs_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire cbfs_pkg::in_item_t  in_item,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire cbfs_pkg::out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken without a result");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != cbfs_pkg::ST_OK |->
		out_item.out_handle == '0 && out_item.out_depth == '0 && !out_item.out_dominated)
		else $error("node fields set on failing status");
endmodule

bind cyclic_best_first_node_selector_unit cbfs_checker u_cbfs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
	.out_item(out_item)
);
`default_nettype wire
